### design/vci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vci_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int VOL_W = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam int QUEUE_DEPTH = 2;

    localparam int DIFF_W = VOL_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int QUO_W  = VOL_W;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_POINT_COUNT = '0;

    typedef struct packed {
        logic                    lookup;
        logic [IDX_W-1:0]        idx;
        logic signed [VOL_W-1:0] key_or_vol;
        logic signed [VOL_W-1:0] value;
    } t_item;

endpackage

`default_nettype wire

### design/vci_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vci_front #(
    parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
    input  wire logic                           i_valid,
    input  wire logic                           i_kind,
    input  wire logic [vci_pkg::IDX_W-1:0]      i_point_index,
    input  wire logic signed [vci_pkg::VOL_W-1:0] i_point_key,
    input  wire logic signed [vci_pkg::VOL_W-1:0] i_point_value,
    input  wire logic signed [vci_pkg::VOL_W-1:0] i_input_volume,
    input  wire logic                           i_q_full,
    output logic                                o_stall,
    output logic                                o_push,
    output vci_pkg::t_item                      o_item
);

    logic w_accept;
    logic w_keep;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    // loads to slots outside the table are dropped here
    assign w_keep   = (i_kind == vci_pkg::KIND_LOOKUP) || (32'(i_point_index) < MAX_POINTS);
    assign o_push   = w_accept && w_keep;

    always_comb begin
        o_item.lookup     = (i_kind == vci_pkg::KIND_LOOKUP);
        o_item.idx        = i_point_index;
        o_item.key_or_vol = (i_kind == vci_pkg::KIND_LOOKUP) ? i_input_volume : i_point_key;
        o_item.value      = i_point_value;
    end

endmodule

`default_nettype wire

### design/vci_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vci_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vci_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output vci_pkg::t_item      o_item
);

    localparam int QAW = (vci_pkg::QUEUE_DEPTH > 1) ? $clog2(vci_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(vci_pkg::QUEUE_DEPTH + 1);

    vci_pkg::t_item r_slot [vci_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(vci_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(vci_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(vci_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### design/vci_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vci_back #(
    parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [vci_pkg::CNT_W-1:0]        i_point_count,
    input  wire logic                             i_q_empty,
    input  wire vci_pkg::t_item                   i_q_item,
    output logic                                  o_pop,
    input  wire logic                             i_stall,
    output logic                                  o_valid,
    output logic signed [vci_pkg::VOL_W-1:0]      o_routing_volume
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int VOL_W  = vci_pkg::VOL_W;
    localparam int DIFF_W = vci_pkg::DIFF_W;
    localparam int PROD_W = vci_pkg::PROD_W;
    localparam int NUM_W  = vci_pkg::NUM_W;
    localparam int QUO_W  = vci_pkg::QUO_W;
    localparam int SW     = $clog2(QUO_W);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SCAN = 9'b000000010,
        ST_PREP = 9'b000000100,
        ST_MUL1 = 9'b000001000,
        ST_MUL2 = 9'b000010000,
        ST_SUM  = 9'b000100000,
        ST_ABS  = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [VOL_W-1:0] r_key_mem [MAX_POINTS];
    logic [VOL_W-1:0] r_val_mem [MAX_POINTS];
    logic signed [VOL_W-1:0] r_rd_key;
    logic signed [VOL_W-1:0] r_rd_val;

    logic [CW-1:0]            r_i;
    logic signed [VOL_W-1:0]  r_x;
    logic signed [VOL_W-1:0]  r_lk;
    logic signed [VOL_W-1:0]  r_lv;
    logic signed [VOL_W-1:0]  r_uk;
    logic signed [VOL_W-1:0]  r_uv;
    logic signed [DIFF_W-1:0] r_d;
    logic signed [DIFF_W-1:0] r_dv;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_dsh;
    logic [QUO_W-1:0]         r_q;
    logic [SW-1:0]            r_step;
    logic                     r_neg;
    logic signed [VOL_W-1:0]  r_res;
    logic                     r_out_valid;
    logic signed [VOL_W-1:0]  r_out_vol;

    logic [CW-1:0]            w_n;
    logic [CW-1:0]            w_i_next;
    logic [AW-1:0]            w_rd_addr;
    logic [AW-1:0]            w_wr_addr;
    logic                     w_wr_en;
    logic                     w_above;
    logic                     w_last;
    logic                     w_out_free;
    logic signed [DIFF_W-1:0] w_ma;
    logic signed [DIFF_W-1:0] w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [NUM_W-1:0]         w_mag;
    logic [NUM_W-1:0]         w_d_ext;
    logic                     w_ge;
    logic [QUO_W-1:0]         w_q_next;

    assign w_n = (32'(i_point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(i_point_count);

    assign o_pop      = (r_state == ST_IDLE) && !i_q_empty;
    assign w_wr_en    = o_pop && !i_q_item.lookup;
    assign w_wr_addr  = AW'(i_q_item.idx);
    assign w_i_next   = r_i + 1'b1;
    assign w_rd_addr  = (r_state == ST_SCAN) ? w_i_next[AW-1:0] : '0;
    assign w_above    = (r_rd_key > r_x);
    assign w_last     = (w_i_next == w_n);
    assign w_out_free = !r_out_valid || !i_stall;

    // one shared multiplier: lv*d, then (uv-lv)*(x-lk)
    assign w_ma   = (r_state == ST_MUL1) ? {r_lv[VOL_W-1], r_lv} : r_dv;
    assign w_mb   = (r_state == ST_MUL1) ? r_d : r_dx;
    assign w_prod = w_ma * w_mb;

    assign w_mag    = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_d_ext  = {{(NUM_W-DIFF_W){1'b0}}, r_d};
    assign w_ge     = (r_rem >= r_dsh);
    assign w_q_next = {r_q[QUO_W-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && i_q_item.lookup) begin
                    n_state = (w_n == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_above) begin
                    n_state = (r_i == '0) ? ST_OUT : ST_PREP;
                end else if (w_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_PREP: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_SUM;
            ST_SUM:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == SW'(QUO_W - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_key_mem[w_wr_addr] <= i_q_item.key_or_vol;
            r_val_mem[w_wr_addr] <= i_q_item.value;
        end
        r_rd_key <= r_key_mem[w_rd_addr];
        r_rd_val <= r_val_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_q_item.lookup) begin
                    r_x   <= i_q_item.key_or_vol;
                    r_res <= i_q_item.key_or_vol;
                    r_i   <= '0;
                end
            end
            ST_SCAN: begin
                r_res <= r_rd_val;
                if (w_above) begin
                    r_uk <= r_rd_key;
                    r_uv <= r_rd_val;
                end else begin
                    r_lk <= r_rd_key;
                    r_lv <= r_rd_val;
                    r_i  <= w_i_next;
                end
            end
            ST_PREP: begin
                r_d  <= {r_uk[VOL_W-1], r_uk} - {r_lk[VOL_W-1], r_lk};
                r_dv <= {r_uv[VOL_W-1], r_uv} - {r_lv[VOL_W-1], r_lv};
                r_dx <= {r_x[VOL_W-1], r_x} - {r_lk[VOL_W-1], r_lk};
            end
            ST_MUL1: r_p1 <= w_prod;
            ST_MUL2: r_p2 <= w_prod;
            ST_SUM: begin
                r_num <= {r_p1[PROD_W-1], r_p1} + {r_p2[PROD_W-1], r_p2};
            end
            ST_ABS: begin
                // round half away from zero: (2|num| + d) / (2d)
                r_neg  <= r_num[NUM_W-1];
                r_rem  <= {w_mag[NUM_W-2:0], 1'b0} + w_d_ext;
                r_dsh  <= w_d_ext << QUO_W;
                r_q    <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_q    <= w_q_next;
                r_step <= r_step + 1'b1;
                if (r_step == SW'(QUO_W - 1)) begin
                    r_res <= r_neg ? (~w_q_next + 1'b1) : w_q_next;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out_vol <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_routing_volume = r_out_vol;

endmodule

`default_nettype wire

### design/volume_curve_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Volume curve interpolator. Load beats (kind 0) write one breakpoint into a
// MAX_POINTS-entry table and give no result; lookup beats (kind 1) give one
// routing volume, interpolated between breakpoints and rounded half away from
// zero, clamped to the nearest end value outside the curve, or passed through
// when point_count is zero. A two-beat queue between the input and execution
// sides keeps taking input beats, until it is full, while a result waits on a
// stalled output. A load is written as it leaves the queue. A lookup scans the
// table, which has one read port, one slot per cycle over at most point_count
// slots, then, to interpolate, makes two passes through one shared multiplier
// and a 16-step restoring divider. point_count is written through the APB port
// at byte address 0; the user must write it only while the block is idle, and
// the block itself does not enforce this.

module volume_curve_interpolator_top #(
    parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_kind,
    input  wire logic [vci_pkg::IDX_W-1:0]          i_point_index,
    input  wire logic signed [vci_pkg::VOL_W-1:0]   i_point_key,
    input  wire logic signed [vci_pkg::VOL_W-1:0]   i_point_value,
    input  wire logic signed [vci_pkg::VOL_W-1:0]   i_input_volume,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [vci_pkg::VOL_W-1:0]        o_routing_volume,
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic [vci_pkg::APB_AW-1:0]         i_paddr,
    input  wire logic [vci_pkg::APB_DW-1:0]         i_pwdata,
    output logic [vci_pkg::APB_DW-1:0]              o_prdata,
    output logic                                    o_pready
);

    logic [vci_pkg::CNT_W-1:0] r_point_count;
    logic                      w_sel_count;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_q_full;
    logic                      w_q_empty;
    vci_pkg::t_item            w_push_item;
    vci_pkg::t_item            w_head_item;

    assign o_pready    = 1'b1;
    assign w_sel_count = (i_paddr[vci_pkg::APB_AW-1:2] == vci_pkg::REG_POINT_COUNT);
    assign o_prdata    = w_sel_count ? vci_pkg::APB_DW'(r_point_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_sel_count) begin
            r_point_count <= i_pwdata[vci_pkg::CNT_W-1:0];
        end
    end

    vci_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_valid        (i_valid),
        .i_kind         (i_kind),
        .i_point_index  (i_point_index),
        .i_point_key    (i_point_key),
        .i_point_value  (i_point_value),
        .i_input_volume (i_input_volume),
        .i_q_full       (w_q_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    vci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_head_item)
    );

    vci_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_point_count    (r_point_count),
        .i_q_empty        (w_q_empty),
        .i_q_item         (w_head_item),
        .o_pop            (w_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_routing_volume (o_routing_volume)
    );

endmodule

`default_nettype wire
